[src/hte_pkg.sv]
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants of the table-driven huffman encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

	localparam int SYMBOL_COUNT_DEF  = 256;
	localparam int MAX_CODE_BITS_DEF = 14;

	localparam int KIND_W   = 2;
	localparam int SYM_FW   = 8;
	localparam int LEN_W    = 4;
	localparam int CODE_W   = 14;
	localparam int BYTE_W   = 8;
	localparam int PEND_W   = 7;
	localparam int CNT_W    = 3;
	localparam int TOTAL_W  = 5;
	localparam int ACC_W    = 23;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_MISS  = 2'd0,
		OP_CODE  = 2'd1,
		OP_FLUSH = 2'd2
	} cmd_op_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} entry_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} cmd_t;

endpackage

[src/hte_if.sv]
// ----------------------------------------------------------------------------
// hte_if
// Valid/ready channels for input items and output bytes.
// ----------------------------------------------------------------------------
interface hte_in_if import hte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SYM_FW-1:0]   symbol;
	logic [LEN_W-1:0]    code_length;
	logic [CODE_W-1:0]   code_bits;

	modport source (output valid, kind, symbol, code_length, code_bits, input ready);
	modport sink (input valid, kind, symbol, code_length, code_bits, output ready);
endinterface

interface hte_out_if import hte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              status;
	logic              last_of_run;

	modport source (output valid, out_byte, status, last_of_run, input ready);
	modport sink (input valid, out_byte, status, last_of_run, output ready);
endinterface

[src/huffman_table_encoder_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_table_encoder_bit_packer
// Table-driven huffman encoder with an lsb-first byte packer.
// ----------------------------------------------------------------------------
// Channels: items (sink) takes load, encode and flush items; results (source)
// gives packed bytes, a status result for a symbol without a code, and marks
// the final result of each item with last_of_run.
// An accepted item passes the lookup register, a queue slot and the output
// register before its result shows. Throughput: the lookup front takes one
// item per cycle unless stalled; the packer issues one result per cycle while
// results.ready is high, so a two-byte encode holds it for its second byte. A
// four-entry command queue between the two absorbs bursts; loads and unused
// kinds never enter it; encodes and flushes take a slot even with no result.
// Reset: the code presence map is cleared and the pending buffer emptied;
// code table entries are undefined until loaded.
// Stall: the output register holds while results.ready is low; the queue
// keeps taking items until it and the lookup register are full, then
// items.ready drops.
// ----------------------------------------------------------------------------
module huffman_table_encoder_bit_packer import hte_pkg::*; #(
	parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hte_in_if.sink    items,
	hte_out_if.source results
);

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	hte_front #(
		.SYMBOL_COUNT  (SYMBOL_COUNT),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	hte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	hte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.results   (results)
	);

endmodule

[src/hte_front.sv]
// ----------------------------------------------------------------------------
// hte_front
// Accepts items, writes code table entries and looks up symbols to encode.
// ----------------------------------------------------------------------------
module hte_front import hte_pkg::*; #(
	parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hte_in_if.sink    items,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output cmd_t      cmd
);

	localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIM = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

	entry_t                  mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] present_q;

	logic              valid_s1;
	logic              flush_s1;
	logic              hit_s1;
	entry_t            rd_data_s1;

	logic              accept;
	logic              in_range;
	logic [SYM_W-1:0]  addr;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W-1:0] mask;
	logic              is_load;
	logic              is_encode;
	logic              is_flush;

	assign items.ready = !valid_s1 || cmd_ready;
	assign accept      = items.valid && items.ready;
	assign in_range    = {1'b0, items.symbol} < (SYM_FW+1)'(SYMBOL_COUNT);
	assign addr        = items.symbol[SYM_W-1:0];
	assign is_load     = items.kind == KIND_LOAD;
	assign is_encode   = items.kind == KIND_ENCODE;
	assign is_flush    = items.kind == KIND_FLUSH;

	assign len_sat = (items.code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM)
	                                                       : items.code_length;

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			mask[i] = LEN_W'(i) < len_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && in_range) begin
			mem[addr] <= '{len: len_sat, bits: items.code_bits & mask};
		end
		if (accept && is_encode) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (accept && is_load && in_range) begin
			present_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (accept) begin
			// loads and unused kinds end here
			valid_s1 <= is_encode || is_flush;
			flush_s1 <= is_flush;
			hit_s1   <= in_range && present_q[addr];
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign cmd_valid = valid_s1;

	always_comb begin
		cmd.len  = rd_data_s1.len;
		cmd.bits = rd_data_s1.bits;
		if (flush_s1) begin
			cmd.op = OP_FLUSH;
		end else if (hit_s1) begin
			cmd.op = OP_CODE;
		end else begin
			cmd.op = OP_MISS;
		end
	end

endmodule

[src/hte_queue.sv]
// ----------------------------------------------------------------------------
// hte_queue
// Small command queue between lookup and bit packer.
// ----------------------------------------------------------------------------
module hte_queue import hte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t           slots [QUEUE_DEPTH];
	logic [PTR_W:0] wr_ptr_q;
	logic [PTR_W:0] rd_ptr_q;
	logic           full;
	logic           empty;

	assign empty = wr_ptr_q == rd_ptr_q;
	assign full  = (wr_ptr_q[PTR_W] != rd_ptr_q[PTR_W])
	            && (wr_ptr_q[PTR_W-1:0] == rd_ptr_q[PTR_W-1:0]);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = slots[rd_ptr_q[PTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			slots[wr_ptr_q[PTR_W-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

[src/hte_back.sv]
// ----------------------------------------------------------------------------
// hte_back
// Bit packer: appends code bits to a pending buffer; emits bytes and status.
// ----------------------------------------------------------------------------
module hte_back import hte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	hte_out_if.source results
);

	logic [PEND_W-1:0]  pend_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               status_q;
	logic               last_q;
	logic               hold_valid_q;
	logic [BYTE_W-1:0]  hold_byte_q;

	logic               slot_free;
	logic [ACC_W-1:0]   acc;
	logic [TOTAL_W-1:0] total;
	logic               emit1;
	logic               emit2;
	logic [PEND_W-1:0]  pend_nxt;

	assign slot_free = !out_valid_q || results.ready;
	assign cmd_ready = slot_free && !hold_valid_q;

	assign acc   = ACC_W'(pend_q) | (ACC_W'(cmd.bits) << cnt_q);
	assign total = TOTAL_W'(cnt_q) + TOTAL_W'(cmd.len);
	assign emit2 = total[4];
	assign emit1 = total[4] || total[3];

	always_comb begin
		if (emit2) begin
			pend_nxt = acc[2*BYTE_W +: PEND_W];
		end else if (emit1) begin
			pend_nxt = acc[BYTE_W +: PEND_W];
		end else begin
			pend_nxt = acc[PEND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			status_q     <= 1'b0;
			last_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_byte_q  <= '0;
		end else if (slot_free) begin
			if (hold_valid_q) begin
				// second byte of a long code
				out_valid_q  <= 1'b1;
				out_byte_q   <= hold_byte_q;
				status_q     <= 1'b0;
				last_q       <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (cmd_valid) begin
				case (cmd.op)
					OP_MISS: begin
						out_valid_q <= 1'b1;
						out_byte_q  <= '0;
						status_q    <= 1'b1;
						last_q      <= 1'b1;
					end
					OP_CODE: begin
						pend_q       <= pend_nxt;
						cnt_q        <= total[CNT_W-1:0];
						out_valid_q  <= emit1;
						out_byte_q   <= acc[BYTE_W-1:0];
						status_q     <= 1'b0;
						last_q       <= !emit2;
						hold_valid_q <= emit2;
						hold_byte_q  <= acc[BYTE_W +: BYTE_W];
					end
					OP_FLUSH: begin
						out_valid_q <= cnt_q != '0;
						out_byte_q  <= {1'b0, pend_q};
						status_q    <= 1'b0;
						last_q      <= 1'b1;
						pend_q      <= '0;
						cnt_q       <= '0;
					end
					default: begin
						out_valid_q <= 1'b0;
					end
				endcase
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_byte    = out_byte_q;
	assign results.status      = status_q;
	assign results.last_of_run = last_q;

endmodule

[src/hte_checker.sv]
// ----------------------------------------------------------------------------
// hte_checker
// Port-level checks on the result channel of the encoder.
// ----------------------------------------------------------------------------
module hte_checker import hte_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              status,
	input logic              last_of_run
);

	// a stalled transaction keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(status) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> out_byte == '0 && last_of_run)
		else $error("status result malformed");

	a_first_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !status)
		else $error("non-final result carries status");

	// the second byte of a long code follows right after the first
	a_second_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && !status && last_of_run)
		else $error("second byte missing");

endmodule

bind huffman_table_encoder_bit_packer hte_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_byte    (results.out_byte),
	.status      (results.status),
	.last_of_run (results.last_of_run)
);
